[rtl/core/iapi_pkg.sv]
// ----------------------------------------------------------------------------
// iapi_pkg
// Shared constants, register indexes, phase codes and the command/status
// structs between the controller and the datapath of the peak area integrator.
// ----------------------------------------------------------------------------
package iapi_pkg;

    localparam int MAX_BLOCK_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int AREA_BITS_DEF   = 48;

    // configuration register widths
    localparam int LEN_W      = 13;
    localparam int TOL_W      = 16;
    localparam int THR_W      = 16;
    localparam int PER_W      = 8;
    localparam int CNT_W      = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int PHASE_W    = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INJ_COUNT = 3'd4;

    // configuration reset values
    localparam logic [LEN_W-1:0] BLOCK_LEN_RST = 13'd16;
    localparam logic [TOL_W-1:0] TOLERANCE_RST = 16'd64;
    localparam logic [THR_W-1:0] THRESHOLD_RST = 16'd256;
    localparam logic [PER_W-1:0] PERIOD_RST    = 8'd1;
    localparam logic [CNT_W-1:0] INJ_COUNT_RST = 8'd1;

    // measurement phases
    localparam logic [PHASE_W-1:0] PH_FIRST   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SETTLE  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ARMED   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_MEASURE = 3'd3;
    localparam logic [PHASE_W-1:0] PH_TAIL    = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DONE    = 3'd5;

    // blocks always integrated after an injection starts
    localparam int MEASURE_BLOCKS = 2;

    typedef struct packed {
        logic load;      // capture input sample
        logic calc;      // distance, threshold hit, area product
        logic upd;       // phase update and block statistics
        logic div_step;  // one quotient bit of the mean divider
        logic fix;       // floor correction of the mean
        logic settle;    // baseline settle check at block end
        logic emit;      // load the output register
    } t_dp_cmd;

    typedef struct packed {
        logic need_div;  // block end in a settling phase
        logic div_last;  // final divider step
        logic out_free;  // output register can take a beat
    } t_dp_sts;

endpackage

[rtl/core/iapi_ctrl.sv]
// ----------------------------------------------------------------------------
// iapi_ctrl
// Sequencer of the peak area integrator: steps one sample through calc,
// update, optional mean division and settle, then hands it to the output.
// ----------------------------------------------------------------------------
module iapi_ctrl
    import iapi_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIX  = 3'd4;
    localparam logic [2:0] S_SETL = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = i_sts.need_div ? S_DIV : S_OUT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_SETL;
            end
            S_SETL: begin
                o_cmd.settle = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // a divide pass always ends in the settle check
    a_div_to_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_last) |=> (r_state == S_FIX) ##1 (r_state == S_SETL))
        else $error("divider did not hand over to settle");

    // every accepted sample is sequenced through calc and update
    a_load_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_CALC) ##1 (r_state == S_UPD))
        else $error("sample not sequenced after load");

endmodule

[rtl/core/iapi_dp.sv]
// ----------------------------------------------------------------------------
// iapi_dp
// Datapath: configuration registers, block statistics, baseline, saturating
// area, bit-serial mean divider and the output register.
// ----------------------------------------------------------------------------
module iapi_dp
    import iapi_pkg::*;
#(
    parameter int MAX_BLOCK   = MAX_BLOCK_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int AREA_BITS   = AREA_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_wdata,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  t_dp_cmd                       i_cmd,
    output t_dp_sts                       o_sts,
    input  logic                          i_m_ready,
    output logic                          o_m_valid,
    output logic [PHASE_W-1:0]            o_phase,
    output logic [SAMPLE_BITS-1:0]        o_baseline,
    output logic                          o_area_valid,
    output logic [AREA_BITS-1:0]          o_peak_area,
    output logic [CNT_W-1:0]              o_inj_number,
    output logic                          o_all_done
);

    localparam int POS_BITS  = $clog2(MAX_BLOCK + 1);
    localparam int SUM_BITS  = SAMPLE_BITS + POS_BITS;
    localparam int DIST_BITS = SAMPLE_BITS + 1;
    localparam int PROD_BITS = DIST_BITS + PER_W;
    localparam int WIDE      = (PROD_BITS > AREA_BITS ? PROD_BITS : AREA_BITS) + 1;
    localparam int DCNT_BITS = $clog2(SUM_BITS);
    localparam int CMP_BITS  = (SAMPLE_BITS > TOL_W ? SAMPLE_BITS : TOL_W) + 2;

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [WIDE-1:0] AREA_MAX_W = {{(WIDE-AREA_BITS){1'b0}}, {AREA_BITS{1'b1}}};

    // configuration
    logic [LEN_W-1:0] r_blen;
    logic [TOL_W-1:0] r_tol;
    logic [THR_W-1:0] r_thr;
    logic [PER_W-1:0] r_per;
    logic [CNT_W-1:0] r_icnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blen <= BLOCK_LEN_RST;
            r_tol  <= TOLERANCE_RST;
            r_thr  <= THRESHOLD_RST;
            r_per  <= PERIOD_RST;
            r_icnt <= INJ_COUNT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_BLOCK_LEN: r_blen <= i_cfg_wdata[LEN_W-1:0];
                CFG_TOLERANCE: r_tol  <= i_cfg_wdata[TOL_W-1:0];
                CFG_THRESHOLD: r_thr  <= i_cfg_wdata[THR_W-1:0];
                CFG_PERIOD:    r_per  <= i_cfg_wdata[PER_W-1:0];
                CFG_INJ_COUNT: r_icnt <= i_cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // state
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic [PHASE_W-1:0]            r_phase,  n_phase;
    logic [POS_BITS-1:0]           r_pos,    n_pos;
    logic signed [SUM_BITS-1:0]    r_sum,    n_sum;
    logic signed [SAMPLE_BITS-1:0] r_min,    n_min;
    logic signed [SAMPLE_BITS-1:0] r_max,    n_max;
    logic signed [SAMPLE_BITS-1:0] r_pmin,   n_pmin;
    logic signed [SAMPLE_BITS-1:0] r_pmax,   n_pmax;
    logic signed [SAMPLE_BITS-1:0] r_base,   n_base;
    logic [AREA_BITS-1:0]          r_area,   n_area;
    logic [CNT_W-1:0]              r_inj,    n_inj;
    logic                          r_mbi,    n_mbi;
    logic                          r_avalid, n_avalid;
    logic [PROD_BITS-1:0]          r_prod;
    logic                          r_hit;
    logic [SUM_BITS-1:0]           r_quo,    n_quo;
    logic [POS_BITS-1:0]           r_rem,    n_rem;
    logic [DCNT_BITS-1:0]          r_dcnt,   n_dcnt;
    logic                          r_neg,    n_neg;
    logic signed [SAMPLE_BITS-1:0] r_mean;

    // effective block length
    logic [POS_BITS-1:0] eff_len;
    always_comb begin
        if (r_blen == '0) begin
            eff_len = POS_BITS'(1);
        end else if (32'(r_blen) > MAX_BLOCK) begin
            eff_len = POS_BITS'(MAX_BLOCK);
        end else begin
            eff_len = POS_BITS'(r_blen);
        end
    end

    // distance from baseline
    logic signed [DIST_BITS-1:0] diff;
    logic [DIST_BITS-1:0]        dist_abs;
    assign diff = $signed({r_sample[SAMPLE_BITS-1], r_sample})
                - $signed({r_base[SAMPLE_BITS-1], r_base});
    assign dist_abs = diff[DIST_BITS-1] ? DIST_BITS'(-diff) : DIST_BITS'(diff);

    // block statistics with the current sample taken in
    logic signed [SUM_BITS-1:0]    t_sum;
    logic signed [SAMPLE_BITS-1:0] t_min, t_max;
    logic [POS_BITS-1:0]           t_pos;
    logic                          t_end;
    assign t_sum = r_sum + $signed({{POS_BITS{r_sample[SAMPLE_BITS-1]}}, r_sample});
    assign t_min = (r_sample < r_min) ? r_sample : r_min;
    assign t_max = (r_sample > r_max) ? r_sample : r_max;
    assign t_pos = r_pos + POS_BITS'(1);
    assign t_end = (t_pos >= eff_len);

    // saturating area add; a new measurement starts from zero
    logic [WIDE-1:0]      term_w, asum_w;
    logic [AREA_BITS-1:0] area_base, area_add;
    assign term_w    = (WIDE'(r_prod) > AREA_MAX_W) ? AREA_MAX_W : WIDE'(r_prod);
    assign area_base = (r_phase == PH_ARMED) ? '0 : r_area;
    assign asum_w    = WIDE'(area_base) + term_w;
    assign area_add  = (asum_w > AREA_MAX_W) ? {AREA_BITS{1'b1}} : asum_w[AREA_BITS-1:0];

    // divider step
    logic [POS_BITS:0] div_sh;
    logic              div_ge;
    assign div_sh = {r_rem, r_quo[SUM_BITS-1]};
    assign div_ge = (div_sh >= {1'b0, r_pos});

    // floor correction
    logic [SUM_BITS:0]        q_plus;
    logic signed [SUM_BITS:0] mean_full;
    assign q_plus    = {1'b0, r_quo} + (SUM_BITS+1)'(r_rem != '0);
    assign mean_full = r_neg ? -$signed(q_plus) : $signed({1'b0, r_quo});

    // settle window
    logic signed [CMP_BITS-1:0] mean_c, lo_c, hi_c, tol_c;
    logic                       settled;
    logic [CNT_W-1:0]           inj_inc;
    assign mean_c  = $signed({{(CMP_BITS-SAMPLE_BITS){r_mean[SAMPLE_BITS-1]}}, r_mean});
    assign tol_c   = $signed({{(CMP_BITS-TOL_W){1'b0}}, r_tol});
    assign lo_c    = $signed({{(CMP_BITS-SAMPLE_BITS){r_pmin[SAMPLE_BITS-1]}}, r_pmin}) - tol_c;
    assign hi_c    = $signed({{(CMP_BITS-SAMPLE_BITS){r_pmax[SAMPLE_BITS-1]}}, r_pmax}) + tol_c;
    assign settled = (mean_c > lo_c) && (mean_c < hi_c);
    assign inj_inc = r_inj + CNT_W'(1);

    logic [SUM_BITS-1:0] sum_mag;
    assign sum_mag = t_sum[SUM_BITS-1] ? SUM_BITS'(-t_sum) : SUM_BITS'(t_sum);

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_sum    = r_sum;
        n_min    = r_min;
        n_max    = r_max;
        n_pmin   = r_pmin;
        n_pmax   = r_pmax;
        n_base   = r_base;
        n_area   = r_area;
        n_inj    = r_inj;
        n_mbi    = r_mbi;
        n_avalid = r_avalid;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_dcnt   = r_dcnt;
        n_neg    = r_neg;

        if (i_cmd.upd) begin
            case (r_phase)
                PH_FIRST: begin
                    if (t_end) begin
                        n_pmin  = t_min;
                        n_pmax  = t_max;
                        n_pos   = '0;
                        n_sum   = '0;
                        n_min   = S_MAX;
                        n_max   = S_MIN;
                        n_phase = PH_SETTLE;
                    end else begin
                        n_pos = t_pos;
                        n_sum = t_sum;
                        n_min = t_min;
                        n_max = t_max;
                    end
                end
                PH_SETTLE, PH_TAIL: begin
                    if (r_phase == PH_TAIL) begin
                        n_area = area_add;
                    end
                    n_pos = t_pos;
                    n_sum = t_sum;
                    n_min = t_min;
                    n_max = t_max;
                    // kick off the mean divider; block stays until settle
                    n_quo  = sum_mag;
                    n_rem  = '0;
                    n_dcnt = DCNT_BITS'(SUM_BITS - 1);
                    n_neg  = t_sum[SUM_BITS-1];
                end
                PH_ARMED: begin
                    if (r_hit) begin
                        n_area  = area_add;
                        n_phase = PH_MEASURE;
                        if (eff_len == POS_BITS'(1)) begin
                            n_pos = '0;
                            n_sum = '0;
                            n_min = S_MAX;
                            n_max = S_MIN;
                            n_mbi = 1'b1;
                        end else begin
                            n_pos = POS_BITS'(1);
                            n_sum = $signed({{POS_BITS{r_sample[SAMPLE_BITS-1]}}, r_sample});
                            n_min = r_sample;
                            n_max = r_sample;
                            n_mbi = 1'b0;
                        end
                    end
                end
                PH_MEASURE: begin
                    n_area = area_add;
                    if (t_end) begin
                        if ((32'(r_mbi) + 1) >= MEASURE_BLOCKS) begin
                            n_pmin  = t_min;
                            n_pmax  = t_max;
                            n_phase = PH_TAIL;
                        end else begin
                            n_mbi = 1'b1;
                        end
                        n_pos = '0;
                        n_sum = '0;
                        n_min = S_MAX;
                        n_max = S_MIN;
                    end else begin
                        n_pos = t_pos;
                        n_sum = t_sum;
                        n_min = t_min;
                        n_max = t_max;
                    end
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end

        if (i_cmd.div_step) begin
            n_quo  = {r_quo[SUM_BITS-2:0], div_ge};
            n_rem  = div_ge ? POS_BITS'(div_sh - {1'b0, r_pos}) : div_sh[POS_BITS-1:0];
            n_dcnt = r_dcnt - DCNT_BITS'(1);
        end

        if (i_cmd.settle) begin
            if (settled) begin
                n_base = r_mean;
                if (r_phase == PH_TAIL) begin
                    n_avalid = 1'b1;
                    n_inj    = inj_inc;
                    n_phase  = (inj_inc >= r_icnt) ? PH_DONE : PH_ARMED;
                end else begin
                    n_phase  = (r_inj >= r_icnt) ? PH_DONE : PH_ARMED;
                end
            end else begin
                n_pmin = r_min;
                n_pmax = r_max;
            end
            n_pos = '0;
            n_sum = '0;
            n_min = S_MAX;
            n_max = S_MIN;
        end

        if (i_cmd.emit) begin
            n_avalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FIRST;
            r_pos    <= '0;
            r_sum    <= '0;
            r_min    <= S_MAX;
            r_max    <= S_MIN;
            r_pmin   <= '0;
            r_pmax   <= '0;
            r_base   <= '0;
            r_area   <= '0;
            r_inj    <= '0;
            r_mbi    <= 1'b0;
            r_avalid <= 1'b0;
            r_dcnt   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_sum    <= n_sum;
            r_min    <= n_min;
            r_max    <= n_max;
            r_pmin   <= n_pmin;
            r_pmax   <= n_pmax;
            r_base   <= n_base;
            r_area   <= n_area;
            r_inj    <= n_inj;
            r_mbi    <= n_mbi;
            r_avalid <= n_avalid;
            r_dcnt   <= n_dcnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_neg <= n_neg;
        if (i_cmd.load) begin
            r_sample <= i_sample;
        end
        if (i_cmd.calc) begin
            r_prod <= PROD_BITS'(r_per) * PROD_BITS'(dist_abs);
            r_hit  <= (32'(dist_abs) >= 32'(r_thr));
        end
        if (i_cmd.fix) begin
            r_mean <= mean_full[SAMPLE_BITS-1:0];
        end
    end

    // output register
    logic                   r_m_valid;
    logic [PHASE_W-1:0]     r_o_phase;
    logic [SAMPLE_BITS-1:0] r_o_base;
    logic                   r_o_avalid;
    logic [AREA_BITS-1:0]   r_o_area;
    logic [CNT_W-1:0]       r_o_inj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_phase  <= r_phase;
            r_o_base   <= r_base;
            r_o_avalid <= r_avalid;
            r_o_area   <= r_area;
            r_o_inj    <= r_inj;
        end
    end

    assign o_m_valid    = r_m_valid;
    assign o_phase      = r_o_phase;
    assign o_baseline   = r_o_base;
    assign o_area_valid = r_o_avalid;
    assign o_peak_area  = r_o_area;
    assign o_inj_number = r_o_inj;
    assign o_all_done   = (r_o_phase == PH_DONE);

    assign o_sts.need_div = ((r_phase == PH_SETTLE) || (r_phase == PH_TAIL)) && t_end;
    assign o_sts.div_last = (r_dcnt == '0);
    assign o_sts.out_free = !r_m_valid || i_m_ready;

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pos) <= MAX_BLOCK)
        else $error("block position beyond maximum block length");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_pos != '0) && (r_rem < r_pos))
        else $error("divider remainder out of range");

    a_avalid_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_o_avalid) |-> (r_o_phase == PH_ARMED || r_o_phase == PH_DONE))
        else $error("finished area reported outside armed or done");

endmodule

[rtl/core/injection_peak_area_integrator.sv]
// ----------------------------------------------------------------------------
// injection_peak_area_integrator
// Baseline tracking and injection peak area measurement over a sample stream.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: sample
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: phase..all_done, tuser: area_valid
//  cfg       in   i_cfg_wr_en                  i_cfg_index, i_cfg_wdata
//
//  One result beat per sample. A sample steps through IDLE, CALC, UPD and OUT
//  before the next accept; a block end in the settling phases adds the
//  bit-serial mean divider steps (DIV for each quotient bit, then FIX and SETL).
//  The output register lets the next sample enter while a beat waits.
//  i_rst_n is synchronous, active low; config resets to its default values.
//  A stalled output holds the sequencer before the output stage.
// ----------------------------------------------------------------------------
module injection_peak_area_integrator
    import iapi_pkg::*;
#(
    parameter int MAX_BLOCK   = MAX_BLOCK_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int AREA_BITS   = AREA_BITS_DEF,
    localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((PHASE_W + SAMPLE_BITS + AREA_BITS + CNT_W + 1 + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_W-1:0]       s_axis_tdata,   // sample
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // phase, baseline_level, peak_area,
                                                  // injection_number, all_done
    output logic                  m_axis_tuser    // area_valid
);

    localparam int PACK_W = PHASE_W + SAMPLE_BITS + AREA_BITS + CNT_W + 1;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    logic [PHASE_W-1:0]     o_phase_w;
    logic [SAMPLE_BITS-1:0] baseline_w;
    logic [AREA_BITS-1:0]   area_w;
    logic [CNT_W-1:0]       inj_w;
    logic                   done_w;

    iapi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    iapi_dp #(
        .MAX_BLOCK   (MAX_BLOCK),
        .SAMPLE_BITS (SAMPLE_BITS),
        .AREA_BITS   (AREA_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_sample     ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_m_ready    (m_axis_tready),
        .o_m_valid    (m_axis_tvalid),
        .o_phase      (o_phase_w),
        .o_baseline   (baseline_w),
        .o_area_valid (m_axis_tuser),
        .o_peak_area  (area_w),
        .o_inj_number (inj_w),
        .o_all_done   (done_w)
    );

    assign m_axis_tdata = OUT_W'({done_w, inj_w, area_w, baseline_w, o_phase_w});

    // packing width sanity, tied to the payload layout
    if (PACK_W > OUT_W) begin : g_pack_chk
        $fatal(1, "output packing overflow");
    end

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the injection peak area integrator. A scoreboard
// object tracks the blocks, the baseline settling, arming, measuring and the
// saturating area, and checks every output beat field by field. Stimulus is
// a short set of edge codes, then baseline/pulse shaped sample runs under
// changing configurations and random backpressure on both streams.
// ----------------------------------------------------------------------------
module testbench
    import iapi_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OUT_W          = 80;
    localparam int SETTLE_CYCLES  = 40;
    localparam int END_CYCLES     = 60;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SEGMENTS       = 15;
    localparam int SEG_ITEMS      = 88;
    localparam longint unsigned AREA_SAT = (64'd1 << AREA_BITS_DEF) - 64'd1;

    localparam logic [CFG_IDX_W-1:0] REG_IDS [5] = '{CFG_BLOCK_LEN, CFG_TOLERANCE,
                                                    CFG_THRESHOLD, CFG_PERIOD,
                                                    CFG_INJ_COUNT};
    localparam logic signed [15:0] EDGE_CODES [7] = '{32767, -32768, -32768, 32767,
                                                     -1, 0, 1};
    localparam logic signed [15:0] SETTLE_CODES [12] = '{0, 2, 0, 2, -32768, 32767,
                                                        1, 1, 1, 1, 0, 2};

    // same bit order as {m_axis_tuser, m_axis_tdata}
    typedef struct packed {
        logic               area_valid;
        logic               all_done;
        logic [7:0]         inj_num;
        logic [47:0]        area;
        logic signed [15:0] baseline;
        logic [2:0]         phase;
    } area_result_t;

    class area_scoreboard;
        logic [LEN_W-1:0]   block_len;
        logic [TOL_W-1:0]   tolerance;
        logic [THR_W-1:0]   threshold;
        logic [PER_W-1:0]   period;
        logic [CNT_W-1:0]   inj_count;

        logic [PHASE_W-1:0] phase;
        longint             blk_pos, blk_sum, blk_min, blk_max;
        longint             prev_min, prev_max, baseline;
        longint unsigned    area;
        logic [7:0]         inj_done;
        int                 measured_blocks;

        area_result_t       expected_q[$];
        int                 mismatches = 0;
        int                 beats_checked = 0;
        int                 areas_seen = 0;

        function void clear_block();
            blk_pos = 0;
            blk_sum = 0;
            blk_min = 32767;
            blk_max = -32768;
        endfunction

        function void reset_model();
            block_len = BLOCK_LEN_RST;
            tolerance = TOLERANCE_RST;
            threshold = THRESHOLD_RST;
            period    = PERIOD_RST;
            inj_count = INJ_COUNT_RST;
            phase = PH_FIRST;
            clear_block();
            prev_min = 0;
            prev_max = 0;
            baseline = 0;
            area = 0;
            inj_done = 0;
            measured_blocks = 0;
            expected_q.delete();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_BLOCK_LEN: block_len = val[LEN_W-1:0];
                CFG_TOLERANCE: tolerance = val[TOL_W-1:0];
                CFG_THRESHOLD: threshold = val[THR_W-1:0];
                CFG_PERIOD:    period    = val[PER_W-1:0];
                CFG_INJ_COUNT: inj_count = val[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function longint block_limit();
            if (block_len == 0) return 1;
            if (block_len > MAX_BLOCK_DEF) return MAX_BLOCK_DEF;
            return block_len;
        endfunction

        // returns 1 when the sample closes the block
        function bit absorb(longint s);
            blk_sum += s;
            if (s < blk_min) blk_min = s;
            if (s > blk_max) blk_max = s;
            blk_pos++;
            return blk_pos >= block_limit();
        endfunction

        function longint mean_floor();
            longint n;
            n = (blk_pos <= 0) ? 1 : blk_pos;
            if (blk_sum >= 0) return blk_sum / n;
            return -((-blk_sum + n - 1) / n);
        endfunction

        function bit settled(longint m);
            longint tol;
            tol = tolerance;
            return m > prev_min - tol && m < prev_max + tol;
        endfunction

        function longint distance(longint s);
            return (s < baseline) ? baseline - s : s - baseline;
        endfunction

        function void add_area(longint s);
            longint unsigned term;
            term = longint'(period) * distance(s);
            if (term > AREA_SAT) term = AREA_SAT;
            if (area > AREA_SAT - term) area = AREA_SAT;
            else area += term;
        endfunction

        function void keep_previous();
            prev_min = blk_min;
            prev_max = blk_max;
        endfunction

        function void note_sample(logic signed [15:0] smp);
            longint       s;
            longint       m;
            area_result_t r;
            s = smp;
            r.area_valid = 1'b0;
            case (phase)
                PH_FIRST: begin
                    if (absorb(s)) begin
                        keep_previous();
                        clear_block();
                        phase = PH_SETTLE;
                    end
                end
                PH_SETTLE: begin
                    if (absorb(s)) begin
                        m = mean_floor();
                        if (settled(m)) begin
                            baseline = m;
                            phase = (inj_done >= inj_count) ? PH_DONE : PH_ARMED;
                        end else begin
                            keep_previous();
                        end
                        clear_block();
                    end
                end
                PH_ARMED: begin
                    if (distance(s) >= threshold) begin
                        area = 0;
                        measured_blocks = 0;
                        clear_block();
                        phase = PH_MEASURE;
                        add_area(s);
                        // a one-sample block closes on the trigger itself
                        if (absorb(s)) begin
                            clear_block();
                            measured_blocks = 1;
                        end
                    end
                end
                PH_MEASURE: begin
                    add_area(s);
                    if (absorb(s)) begin
                        if (measured_blocks + 1 >= MEASURE_BLOCKS) begin
                            keep_previous();
                            phase = PH_TAIL;
                        end else begin
                            measured_blocks = 1;
                        end
                        clear_block();
                    end
                end
                PH_TAIL: begin
                    add_area(s);
                    if (absorb(s)) begin
                        m = mean_floor();
                        if (settled(m)) begin
                            baseline = m;
                            r.area_valid = 1'b1;
                            inj_done = inj_done + 8'd1;
                            phase = (inj_done >= inj_count) ? PH_DONE : PH_ARMED;
                        end else begin
                            keep_previous();
                        end
                        clear_block();
                    end
                end
                default: phase = PH_DONE;
            endcase
            r.phase    = phase;
            r.baseline = baseline[15:0];
            r.area     = area[47:0];
            r.inj_num  = inj_done;
            r.all_done = (phase == PH_DONE);
            expected_q.push_back(r);
        endfunction

        function void report(string field, longint want, longint got);
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatches++;
        endfunction

        function void check_result(area_result_t got);
            area_result_t want;
            if (expected_q.size() == 0) begin
                $error("output beat with no sample pending");
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            beats_checked++;
            if (want.area_valid) areas_seen++;
            if (got.phase !== want.phase) report("phase", want.phase, got.phase);
            if (got.baseline !== want.baseline)
                report("baseline_level", want.baseline, got.baseline);
            if (got.area_valid !== want.area_valid)
                report("area_valid", want.area_valid, got.area_valid);
            if (got.area !== want.area) report("peak_area", want.area, got.area);
            if (got.inj_num !== want.inj_num)
                report("injection_number", want.inj_num, got.inj_num);
            if (got.all_done !== want.all_done)
                report("all_done", want.all_done, got.all_done);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata;   // sample
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;   // phase, baseline_level, peak_area,
                                           // injection_number, all_done
    logic                  m_axis_tuser;   // area_valid

    area_scoreboard sb;
    int             tx_idle_pct = 19;
    int             rx_idle_pct = 77;
    int             level = 0;
    int             noise_amp = 8;
    int             samples_sent = 0;

    injection_peak_area_integrator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(area_result_t'({m_axis_tuser, m_axis_tdata[75:0]}));
    end

    // ends the run when neither stream moves for too long
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    function automatic logic signed [15:0] clamp_code(int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    // baseline noise around the current level, pulses past the threshold
    // while armed, measuring or in the tail, and some raw codes
    function automatic logic signed [15:0] pick_sample();
        int pulse_pct;
        int mag;
        if ($urandom_range(99, 0) < 8) return 16'($urandom);
        case (sb.phase)
            PH_ARMED:   pulse_pct = 15;
            PH_MEASURE: pulse_pct = 55;
            PH_TAIL:    pulse_pct = 8;
            default:    pulse_pct = 0;
        endcase
        if ($urandom_range(99, 0) < pulse_pct) begin
            mag = int'(sb.threshold) + int'($urandom_range(3000, 0));
            return clamp_code($urandom_range(1, 0) ? level + mag : level - mag);
        end
        return clamp_code(level + int'($urandom_range(2 * noise_amp, 0)) - noise_amp);
    endfunction

    task automatic apply_config(input logic [CFG_DATA_W-1:0] len,
                                input logic [CFG_DATA_W-1:0] tol,
                                input logic [CFG_DATA_W-1:0] thr,
                                input logic [CFG_DATA_W-1:0] per,
                                input logic [CFG_DATA_W-1:0] cnt);
        logic [CFG_DATA_W-1:0] vals [5];
        vals = '{len, tol, thr, per, cnt};
        for (int i = 0; i < 5; i++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= REG_IDS[i];
            i_cfg_wdata <= vals[i];
            sb.write_reg(REG_IDS[i], vals[i]);
            @(negedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic drain(input int extra);
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic send_sample(input logic signed [15:0] smp);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_sample(smp);
        samples_sent++;
        @(negedge i_clk);
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] len, tol, thr, per;
        int                    mode;
        sb = new();
        sb.reset_model();
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // edge codes with a one-sample block and the widest window
        apply_config(0, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255);
        foreach (EDGE_CODES[i]) send_sample(EDGE_CODES[i]);
        drain(SETTLE_CYCLES);
        // zero tolerance, zero threshold, zero weight
        apply_config(2, 0, 0, 0, 8'd255);
        foreach (SETTLE_CODES[i]) send_sample(SETTLE_CODES[i]);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            mode = seg * 3 / SEGMENTS;
            len = (seg == 3) ? 16'd8191 : (seg == 8) ? 16'd4096 :
                  ($urandom_range(99, 0) < 8) ? 16'd0 : 16'($urandom_range(8, 1));
            tol = ($urandom_range(99, 0) < 10) ? 16'($urandom_range(65535, 0))
                                               : 16'($urandom_range(300, 0));
            thr = ($urandom_range(99, 0) < 10) ? 16'($urandom_range(65535, 0))
                                               : 16'($urandom_range(4000, 100));
            per = 16'($urandom_range(255, 0));
            if (seg == 0) begin
                tol = 0;
                thr = 0;
                per = 0;
            end else if (seg == 1) begin
                tol = 16'hFFFF;
                thr = 16'hFFFF;
                per = 16'd255;
            end
            drain(SETTLE_CYCLES);
            apply_config(len, tol, thr, per, 8'd255);
            tx_idle_pct = (mode == 0) ? 19 : (mode == 1) ? 77 : 0;
            rx_idle_pct = (mode == 0) ? 77 : (mode == 1) ? 19 : 0;
            if (seg == 1) level = -32768;
            else if ($urandom_range(99, 0) < 20) level = $urandom_range(1, 0) ? 32767 : -32768;
            else level = int'($urandom_range(40000, 0)) - 20000;
            noise_amp = $urandom_range(200, 1);
            for (int i = 0; i < SEG_ITEMS; i++) begin
                if (seg == 12 && i == 40) drain(0);
                send_sample(pick_sample());
            end
        end

        // last run: a count already reached, so the next measurement finishes
        drain(SETTLE_CYCLES);
        apply_config(4, 64, 500, 1, 1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        level = 0;
        noise_amp = 20;
        for (int i = 0; i < 60; i++) send_sample(pick_sample());
        drain(END_CYCLES);

        $display("Run summary: %0d samples driven, %0d output beats checked, %0d areas reported",
                 samples_sent, sb.beats_checked, sb.areas_seen);
        $display("Configs swept block length, tolerance, threshold and period extremes; "
                 , "finished state reached: %0d", sb.phase == PH_DONE);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/iapi_pkg.sv
rtl/core/iapi_ctrl.sv
rtl/core/iapi_dp.sv
rtl/core/injection_peak_area_integrator.sv
test/testbench.sv
